### sv/efc_pkg.sv
// Shared types, constants and helper functions for the fly camera pose unit.
// Depends on nothing; every other file of the block imports it.
package efc_pkg;

    // Default parameter values
    localparam int POS_FRAC_BITS_DEF   = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 7;
    localparam int CORDIC_STEPS_DEF    = 16;

    // Internal formats
    localparam int TRIG_FRAC = 30;   // sine and cosine fraction bits
    localparam int ATAB_FRAC = 20;   // CORDIC angle fraction bits (degrees)
    localparam int ATAB_LEN  = 24;
    localparam int ZW        = 30;   // CORDIC angle accumulator width
    localparam int CW        = 32;   // CORDIC x and y width
    localparam int MW        = 34;   // multiplier operand width
    localparam int PW        = 2 * MW;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 32'sd652032874;

    // Action codes
    localparam logic [2:0] ACT_ROTATE = 3'd0;
    localparam logic [2:0] ACT_FWD    = 3'd1;
    localparam logic [2:0] ACT_BACK   = 3'd2;
    localparam logic [2:0] ACT_RIGHT  = 3'd3;
    localparam logic [2:0] ACT_LEFT   = 3'd4;
    localparam logic [2:0] ACT_DIR    = 3'd5;

    // Register indexes
    localparam logic [2:0] REG_SPEED       = 3'd0;
    localparam logic [2:0] REG_SENSITIVITY = 3'd1;
    localparam logic [2:0] REG_START_YAW   = 3'd2;
    localparam logic [2:0] REG_START_PITCH = 3'd3;
    localparam logic [2:0] REG_START_X     = 3'd4;
    localparam logic [2:0] REG_START_Y     = 3'd5;
    localparam logic [2:0] REG_START_Z     = 3'd6;

    // Reset values
    localparam logic [15:0]        SPEED_RST       = 16'd640;
    localparam logic [15:0]        SENS_RST        = 16'd410;
    localparam logic signed [15:0] START_YAW_RST   = 16'shD300;
    localparam logic signed [14:0] START_PITCH_RST = 15'sd0;
    localparam logic signed [31:0] START_X_RST     = 32'sd0;
    localparam logic signed [31:0] START_Y_RST     = 32'sd0;
    localparam logic signed [31:0] START_Z_RST     = 32'sd196608;

    // CORDIC status
    typedef struct packed {
        logic busy;
        logic done;
    } efc_cord_stat_t;

    // Arctangent of 2^-i in degrees, ATAB_FRAC fraction bits
    function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        unique case (i)
            5'd0:  r = 30'sd47185920;
            5'd1:  r = 30'sd27855475;
            5'd2:  r = 30'sd14718068;
            5'd3:  r = 30'sd7471121;
            5'd4:  r = 30'sd3750058;
            5'd5:  r = 30'sd1876857;
            5'd6:  r = 30'sd938658;
            5'd7:  r = 30'sd469357;
            5'd8:  r = 30'sd234682;
            5'd9:  r = 30'sd117342;
            5'd10: r = 30'sd58671;
            5'd11: r = 30'sd29335;
            5'd12: r = 30'sd14668;
            5'd13: r = 30'sd7334;
            5'd14: r = 30'sd3667;
            5'd15: r = 30'sd1833;
            5'd16: r = 30'sd917;
            5'd17: r = 30'sd458;
            5'd18: r = 30'sd229;
            5'd19: r = 30'sd115;
            5'd20: r = 30'sd57;
            5'd21: r = 30'sd29;
            5'd22: r = 30'sd14;
            5'd23: r = 30'sd7;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Round a Q.30 value to Q2.14 and saturate
    function automatic logic signed [15:0] to_vec(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] t;
        logic signed [PW-1:0] vmax;
        logic signed [PW-1:0] vmin;
        vmax = PW'(32'sd32767);
        vmin = PW'(-32'sd32768);
        t = (v + PW'(32'sd32768)) >>> 16;
        if (t > vmax) begin
            return 16'sh7FFF;
        end else if (t < vmin) begin
            return 16'sh8000;
        end
        return t[15:0];
    endfunction

endpackage

### sv/euler_fly_camera_update.sv
// Fly camera pose unit: keeps position, yaw and pitch and the unit front,
// right and up vectors (world up +Y), and returns the full pose once per
// action beat. A move runs one speed x time product, then one product per
// axis on the shared multiplier. A rotate runs the offset products, the
// 360-degree wrap steps, two passes of the iterative CORDIC, then the vector
// products on the shared multiplier. Writing start_yaw or start_pitch runs
// the same vector update, and after reset the block runs it once before it
// raises s_ready; both run the rotate sequence without the offset products.
// Unknown actions return the pose unchanged.
module euler_fly_camera_update #(
    parameter int POS_FRAC_BITS   = efc_pkg::POS_FRAC_BITS_DEF,
    parameter int ANGLE_FRAC_BITS = efc_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = efc_pkg::CORDIC_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_action,
    input  logic signed [15:0] s_yaw_offset,
    input  logic signed [15:0] s_pitch_offset,
    input  logic               s_constrain_pitch,
    input  logic [15:0]        s_delta_time,
    input  logic signed [15:0] s_dir_x,
    input  logic signed [15:0] s_dir_y,
    input  logic signed [15:0] s_dir_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    output logic signed [31:0] m_pos_z,
    output logic signed [15:0] m_front_x,
    output logic signed [15:0] m_front_y,
    output logic signed [15:0] m_front_z,
    output logic signed [15:0] m_right_x,
    output logic signed [15:0] m_right_y,
    output logic signed [15:0] m_right_z,
    output logic signed [15:0] m_up_x,
    output logic signed [15:0] m_up_y,
    output logic signed [15:0] m_up_z,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import efc_pkg::*;

    localparam int AW = 10 + ANGLE_FRAC_BITS;
    localparam int SW = 13 + ANGLE_FRAC_BITS;
    localparam logic signed [SW-1:0] FULL_S = SW'(360 * (1 << ANGLE_FRAC_BITS));
    localparam logic signed [SW-1:0] HALF_S = SW'(180 * (1 << ANGLE_FRAC_BITS));
    localparam logic signed [SW-1:0] LIM_S  = SW'(89 * (1 << ANGLE_FRAC_BITS));
    localparam logic signed [AW-1:0] HALF_A = AW'(180 * (1 << ANGLE_FRAC_BITS));
    localparam logic signed [PW-1:0] ROT_RND = PW'(1) <<< (19 - ANGLE_FRAC_BITS);
    localparam logic signed [PW-1:0] POS_RND = PW'(1) <<< (37 - POS_FRAC_BITS);
    localparam logic signed [PW-1:0] PMAX = PW'(32'sh7FFFFFFF);
    localparam logic signed [PW-1:0] PMIN = PW'(32'sh80000000);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ROT  = 3'd1;
    localparam logic [2:0] ST_WRAP = 3'd2;
    localparam logic [2:0] ST_CORD = 3'd3;
    localparam logic [2:0] ST_VEC  = 3'd4;
    localparam logic [2:0] ST_MOVE = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       emit_reg, sel_reg, m_valid_reg;

    logic [15:0]          speed_reg, sens_reg;
    logic signed [AW-1:0] yaw_reg, pitch_reg;
    logic signed [SW-1:0] yaw_w_reg, pitch_w_reg;
    logic signed [31:0]   pos_reg [3];

    logic [2:0]           action_reg;
    logic signed [15:0]   yo_reg, po_reg;
    logic                 cons_reg;
    logic [15:0]          dt_reg;
    logic signed [15:0]   dir_reg [3];
    logic signed [15:0]   front_reg [3];
    logic signed [15:0]   right_reg [3];
    logic signed [15:0]   up_reg [3];
    logic signed [CW-1:0] cy_reg, sy_reg, cp_reg, sp_reg, f0_reg, f2_reg;
    logic signed [PW-1:0] acc_reg;
    logic signed [MW-1:0] vel_reg;
    logic signed [31:0]   opos_reg [3];
    logic signed [15:0]   ofront_reg [3];
    logic signed [15:0]   oright_reg [3];
    logic signed [15:0]   oup_reg [3];

    logic                 s_fire, cfg_fire, out_load;
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod, p_sh, rot_d, pos_d, pos_sum;
    logic signed [MW-1:0] r0, r2;
    logic [1:0]           mv_k, up_k;
    logic signed [15:0]   mv_v;
    logic                 mv_neg;
    logic signed [SW-1:0] yaw_sum, pitch_sum, pitch_clamp;
    logic                 yaw_hi, yaw_lo, pitch_hi, pitch_lo;
    logic                 cord_start;
    efc_cord_stat_t       cord_stat;
    logic signed [CW-1:0] cord_cos, cord_sin;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_ready   = (state_reg == ST_IDLE) && !cfg_valid;
    assign s_fire    = s_valid && s_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // Shared units
    efc_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (prod)
    );

    assign cord_start = (state_reg == ST_CORD) && (cnt_reg == 3'd0);

    efc_cordic #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .STEPS           (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cord_start),
        .angle   (sel_reg ? pitch_reg : yaw_reg),
        .stat    (cord_stat),
        .cos_o   (cord_cos),
        .sin_o   (cord_sin)
    );

    // Datapath helpers
    assign p_sh    = prod >>> TRIG_FRAC;
    assign r0      = (cp_reg < 0) ? MW'(sy_reg) : -MW'(sy_reg);
    assign r2      = (cp_reg < 0) ? -MW'(cy_reg) : MW'(cy_reg);
    assign rot_d   = (prod + ROT_RND) >>> (20 - ANGLE_FRAC_BITS);
    assign yaw_sum = SW'(yaw_reg) + rot_d[SW-1:0];
    assign pitch_sum = SW'(pitch_reg) + rot_d[SW-1:0];
    assign mv_k    = 2'(cnt_reg - 3'd2);
    assign up_k    = 2'(cnt_reg - 3'd3);
    assign mv_neg  = (action_reg == ACT_BACK) || (action_reg == ACT_LEFT);
    assign pos_d   = (prod + POS_RND) >>> (38 - POS_FRAC_BITS);
    assign pos_sum = PW'(pos_reg[up_k]) + pos_d;
    assign yaw_hi  = (yaw_w_reg >= HALF_S);
    assign yaw_lo  = (yaw_w_reg < -HALF_S);
    assign pitch_hi = (pitch_w_reg >= HALF_S);
    assign pitch_lo = (pitch_w_reg < -HALF_S);

    // Clamp pitch on request
    always_comb begin
        pitch_clamp = pitch_sum;
        if (cons_reg) begin
            if (pitch_sum > LIM_S) begin
                pitch_clamp = LIM_S;
            end else if (pitch_sum < -LIM_S) begin
                pitch_clamp = -LIM_S;
            end
        end
    end

    // Pick the move direction component
    always_comb begin
        unique case (action_reg)
            ACT_FWD, ACT_BACK:   mv_v = front_reg[mv_k];
            ACT_RIGHT, ACT_LEFT: mv_v = right_reg[mv_k];
            default:             mv_v = dir_reg[mv_k];
        endcase
    end

    // Steer the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_ROT: begin
                mul_a = (cnt_reg == 3'd0) ? MW'(yo_reg) : MW'(po_reg);
                mul_b = MW'(sens_reg);
            end
            ST_MOVE: begin
                if (cnt_reg == 3'd0) begin
                    mul_a = MW'(speed_reg);
                    mul_b = MW'(dt_reg);
                end else begin
                    mul_a = vel_reg;
                    mul_b = mv_neg ? -MW'(mv_v) : MW'(mv_v);
                end
            end
            ST_VEC: begin
                unique case (cnt_reg)
                    3'd0: begin mul_a = MW'(cy_reg); mul_b = MW'(cp_reg); end
                    3'd1: begin mul_a = MW'(sy_reg); mul_b = MW'(cp_reg); end
                    3'd2: begin mul_a = r2; mul_b = -MW'(sp_reg); end
                    3'd3: begin mul_a = r0; mul_b = MW'(sp_reg); end
                    3'd4: begin mul_a = r2; mul_b = MW'(f0_reg); end
                    3'd5: begin mul_a = -r0; mul_b = MW'(f2_reg); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (cfg_fire) begin
                    if (cfg_index == REG_START_YAW || cfg_index == REG_START_PITCH) begin
                        state_next = ST_WRAP;
                    end
                end else if (s_fire) begin
                    if (s_action == ACT_ROTATE) begin
                        state_next = ST_ROT;
                    end else if (s_action <= ACT_DIR) begin
                        state_next = ST_MOVE;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_ROT: begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd2) begin
                    state_next = ST_WRAP;
                    cnt_next   = '0;
                end
            end
            ST_WRAP: begin
                if (!yaw_hi && !yaw_lo && !pitch_hi && !pitch_lo) begin
                    state_next = ST_CORD;
                    cnt_next   = '0;
                end
            end
            ST_CORD: begin
                if (cnt_reg == 3'd0) begin
                    cnt_next = 3'd1;
                end else if (cord_stat.done) begin
                    cnt_next = '0;
                    if (sel_reg) begin
                        state_next = ST_VEC;
                    end
                end
            end
            ST_VEC: begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd6) begin
                    cnt_next   = '0;
                    state_next = emit_reg ? ST_OUT : ST_IDLE;
                end
            end
            ST_MOVE: begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd5) begin
                    cnt_next   = '0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // Control state, configuration and pose angles and position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_WRAP;
            cnt_reg     <= '0;
            emit_reg    <= 1'b0;
            sel_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            speed_reg   <= SPEED_RST;
            sens_reg    <= SENS_RST;
            yaw_w_reg   <= SW'(START_YAW_RST);
            pitch_w_reg <= SW'(START_PITCH_RST);
            pos_reg[0]  <= START_X_RST;
            pos_reg[1]  <= START_Y_RST;
            pos_reg[2]  <= START_Z_RST;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    sel_reg <= 1'b0;
                    if (cfg_fire) begin
                        emit_reg    <= 1'b0;
                        yaw_w_reg   <= SW'(yaw_reg);
                        pitch_w_reg <= SW'(pitch_reg);
                        unique case (cfg_index)
                            REG_SPEED:       speed_reg <= cfg_data[15:0];
                            REG_SENSITIVITY: sens_reg  <= cfg_data[15:0];
                            REG_START_YAW:   yaw_w_reg <= SW'($signed(cfg_data[15:0]));
                            REG_START_PITCH: pitch_w_reg <= SW'($signed(cfg_data[14:0]));
                            REG_START_X:     pos_reg[0] <= $signed(cfg_data);
                            REG_START_Y:     pos_reg[1] <= $signed(cfg_data);
                            REG_START_Z:     pos_reg[2] <= $signed(cfg_data);
                            default: ;
                        endcase
                    end else if (s_fire) begin
                        emit_reg <= 1'b1;
                    end
                end
                ST_ROT: begin
                    if (cnt_reg == 3'd1) begin
                        yaw_w_reg <= yaw_sum;
                    end else if (cnt_reg == 3'd2) begin
                        pitch_w_reg <= pitch_clamp;
                    end
                end
                ST_WRAP: begin
                    // Step each angle one turn toward [-180, 180)
                    if (yaw_hi) begin
                        yaw_w_reg <= yaw_w_reg - FULL_S;
                    end else if (yaw_lo) begin
                        yaw_w_reg <= yaw_w_reg + FULL_S;
                    end
                    if (pitch_hi) begin
                        pitch_w_reg <= pitch_w_reg - FULL_S;
                    end else if (pitch_lo) begin
                        pitch_w_reg <= pitch_w_reg + FULL_S;
                    end
                end
                ST_CORD: begin
                    if (cnt_reg != 3'd0 && cord_stat.done) begin
                        sel_reg <= 1'b1;
                    end
                end
                ST_MOVE: begin
                    if (cnt_reg >= 3'd3) begin
                        if (pos_sum > PMAX) begin
                            pos_reg[up_k] <= 32'sh7FFFFFFF;
                        end else if (pos_sum < PMIN) begin
                            pos_reg[up_k] <= 32'sh80000000;
                        end else begin
                            pos_reg[up_k] <= pos_sum[31:0];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Commit wrapped angles once in range
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            yaw_reg   <= '0;
            pitch_reg <= '0;
        end else if (state_reg == ST_WRAP && !yaw_hi && !yaw_lo && !pitch_hi && !pitch_lo) begin
            yaw_reg   <= yaw_w_reg[AW-1:0];
            pitch_reg <= pitch_w_reg[AW-1:0];
        end
    end

    // Working payload, vectors and the output register
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            action_reg <= s_action;
            yo_reg     <= s_yaw_offset;
            po_reg     <= s_pitch_offset;
            cons_reg   <= s_constrain_pitch;
            dt_reg     <= s_delta_time;
            dir_reg[0] <= s_dir_x;
            dir_reg[1] <= s_dir_y;
            dir_reg[2] <= s_dir_z;
        end
        if (state_reg == ST_CORD && cnt_reg != 3'd0 && cord_stat.done) begin
            if (sel_reg) begin
                cp_reg <= cord_cos;
                sp_reg <= cord_sin;
            end else begin
                cy_reg <= cord_cos;
                sy_reg <= cord_sin;
            end
        end
        if (state_reg == ST_MOVE && cnt_reg == 3'd1) begin
            vel_reg <= prod[MW-1:0];
        end
        if (state_reg == ST_VEC) begin
            unique case (cnt_reg)
                3'd1: begin
                    f0_reg       <= p_sh[CW-1:0];
                    front_reg[0] <= to_vec(p_sh);
                end
                3'd2: begin
                    f2_reg       <= p_sh[CW-1:0];
                    front_reg[2] <= to_vec(p_sh);
                    front_reg[1] <= to_vec(PW'(sp_reg));
                    right_reg[0] <= to_vec(PW'(r0));
                    right_reg[1] <= '0;
                    right_reg[2] <= to_vec(PW'(r2));
                end
                3'd3: up_reg[0] <= to_vec(p_sh);
                3'd4: up_reg[2] <= to_vec(p_sh);
                3'd5: acc_reg   <= prod;
                3'd6: up_reg[1] <= to_vec((acc_reg + prod) >>> TRIG_FRAC);
                default: ;
            endcase
        end
        if (out_load) begin
            opos_reg   <= pos_reg;
            ofront_reg <= front_reg;
            oright_reg <= right_reg;
            oup_reg    <= up_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_pos_x   = opos_reg[0];
    assign m_pos_y   = opos_reg[1];
    assign m_pos_z   = opos_reg[2];
    assign m_front_x = ofront_reg[0];
    assign m_front_y = ofront_reg[1];
    assign m_front_z = ofront_reg[2];
    assign m_right_x = oright_reg[0];
    assign m_right_y = oright_reg[1];
    assign m_right_z = oright_reg[2];
    assign m_up_x    = oup_reg[0];
    assign m_up_y    = oup_reg[1];
    assign m_up_z    = oup_reg[2];

    // Waiting on the rotator means it is running or has just finished
    a_cord_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CORD && cnt_reg != 3'd0) |-> (cord_stat.busy || cord_stat.done))
        else $error("sequencer waits on an idle CORDIC");

    // Angles fed to the rotator are wrapped
    a_yaw_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_VEC) |-> (yaw_reg >= -HALF_A && yaw_reg < HALF_A
                                   && pitch_reg >= -HALF_A && pitch_reg < HALF_A))
        else $error("angle outside [-180, 180)");

    // Right vector stays horizontal
    a_right_flat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_right_y == 16'sd0))
        else $error("right vector has a vertical component");

endmodule

### sv/efc_mul.sv
// Shared signed multiplier with a registered product.
// Depends on efc_pkg for the operand width.
module efc_mul (
    input  logic                          aclk,
    input  logic signed [efc_pkg::MW-1:0] a,
    input  logic signed [efc_pkg::MW-1:0] b,
    output logic signed [efc_pkg::PW-1:0] p
);
    import efc_pkg::*;

    logic signed [PW-1:0] p_reg;

    // Register the product
    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

### sv/efc_cordic.sv
// Iterative CORDIC rotator: cosine and sine (Q.30) of an angle in degrees.
// One micro-rotation per cycle; depends on efc_pkg for the arctangent table.
module efc_cordic #(
    parameter int ANGLE_FRAC_BITS = efc_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int STEPS           = efc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic signed [10+ANGLE_FRAC_BITS-1:0]   angle,
    output efc_pkg::efc_cord_stat_t                stat,
    output logic signed [efc_pkg::CW-1:0]          cos_o,
    output logic signed [efc_pkg::CW-1:0]          sin_o
);
    import efc_pkg::*;

    localparam int AW = 10 + ANGLE_FRAC_BITS;
    localparam int N  = (STEPS < ATAB_LEN) ? STEPS : ATAB_LEN;
    localparam logic signed [ZW-1:0] NINETY = ZW'(90 * (1 << ATAB_FRAC));
    localparam logic signed [ZW-1:0] HALF_TURN = ZW'(180 * (1 << ATAB_FRAC));

    logic signed [CW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [4:0]           i_reg;
    logic                 neg_reg, busy_reg, done_reg;

    logic signed [ZW-1:0] z0;
    logic signed [CW-1:0] xs, ys;
    logic                 last;

    assign z0   = ZW'(angle) <<< (ATAB_FRAC - ANGLE_FRAC_BITS);
    assign xs   = x_reg >>> i_reg;
    assign ys   = y_reg >>> i_reg;
    assign last = (i_reg == 5'(N - 1));

    // Fold into +-90, then rotate one step a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                i_reg    <= '0;
                x_reg    <= CORDIC_GAIN;
                y_reg    <= '0;
                if (z0 > NINETY) begin
                    z_reg   <= z0 - HALF_TURN;
                    neg_reg <= 1'b1;
                end else if (z0 < -NINETY) begin
                    z_reg   <= z0 + HALF_TURN;
                    neg_reg <= 1'b1;
                end else begin
                    z_reg   <= z0;
                    neg_reg <= 1'b0;
                end
            end else if (busy_reg) begin
                if (z_reg >= 0) begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_deg(i_reg);
                end else begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_deg(i_reg);
                end
                i_reg <= i_reg + 5'd1;
                if (last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign cos_o     = neg_reg ? -x_reg : x_reg;
    assign sin_o     = neg_reg ? -y_reg : y_reg;

endmodule
